### rtl/core/pdm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pairwise distance matrix block.
package pdm_pkg;

   localparam int IDX_WIDTH  = 6;
   localparam int DIST_WIDTH = 21;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;      // write the accepted point and keep it as the current point
      logic rd;         // fetch the stored point at the row index
      logic load_diff;  // register absolute coordinate differences
      logic load_sq;    // register the squares
      logic load_sum;   // register the sum of squares
      logic root_start; // launch the square root unit
      logic emit_pair;  // present an off-diagonal beat
      logic emit_diag;  // present the diagonal beat
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic both;       // fetched and current point are both present
      logic root_done;  // square root result is ready
   } stat_type;

endpackage

### rtl/core/pairwise_distance_matrix.sv
`timescale 1ns / 1ps
// Top level of the pairwise Euclidean distance matrix engine.
//
// Each accepted point (start high while busy is low) is written to the next slot of the
// point store and then compared with every earlier point of its set, in increasing index
// order; one result beat per pair appears on the rsp_ ports, marked by rsp_valid for a
// single cycle, and a diagonal beat with zero distance and rsp_last_of_run set closes the
// run. The receiver cannot stall, so it must take every beat in the cycle it appears.
// For each pair the stored point is fetched; a pair in which either point is missing
// gets its beat without any arithmetic, while a pair of present points passes through
// the difference, square and sum registers and then the iterative square root unit,
// which resolves one root bit per cycle. A point that arrives with the store full and
// without first_of_set is dropped on acceptance and produces no beats. The store needs
// no clearing pass after reset: only entries written in the current set are ever read.
module pairwise_distance_matrix #(
   parameter int MAX_POINTS  = 64,
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic                          req_present,
   input  logic                          req_first_of_set,
   output logic                          rsp_valid,
   output logic [pdm_pkg::IDX_WIDTH-1:0] rsp_row_index,
   output logic [pdm_pkg::IDX_WIDTH-1:0] rsp_col_index,
   output logic [pdm_pkg::DIST_WIDTH-1:0] rsp_distance,
   output logic                          rsp_distance_defined,
   output logic                          rsp_last_of_run
);
   import pdm_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);

   cmd_type       cmd;
   stat_type      stat;
   logic [IW-1:0] row_idx;
   logic [IW-1:0] col_idx;

   // The controller owns the indices and the sequencing; the datapath holds every
   // payload register, including the outgoing beat.
   pdm_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .first_of_set (req_first_of_set),
      .busy         (busy),
      .cmd          (cmd),
      .stat         (stat),
      .row_idx      (row_idx),
      .col_idx      (col_idx)
   );

   pdm_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .row_idx              (row_idx),
      .col_idx              (col_idx),
      .pos_x                (req_pos_x),
      .pos_y                (req_pos_y),
      .pos_z                (req_pos_z),
      .present              (req_present),
      .rsp_valid            (rsp_valid),
      .rsp_row_index        (rsp_row_index),
      .rsp_col_index        (rsp_col_index),
      .rsp_distance         (rsp_distance),
      .rsp_distance_defined (rsp_distance_defined),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

### rtl/core/pdm_isqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle.
module pdm_isqrt #(
   parameter int IN_W = 42
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     radicand,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);
   localparam int OUT_W = IN_W / 2;
   localparam int CNT_W = $clog2(OUT_W + 1);

   logic [IN_W-1:0]  rad_ff, rad_in;
   logic [OUT_W:0]   rem_ff, rem_in;
   logic [OUT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [OUT_W+2:0] rem_sh;
   logic [OUT_W+2:0] trial;
   logic [OUT_W+2:0] diff;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[IN_W-1 -: 2]};
      trial  = (OUT_W+3)'({root_ff, 2'b01});
      ge     = rem_sh >= trial;
      diff   = rem_sh - trial;

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[IN_W-3:0], 2'b00};
         rem_in  = ge ? diff[OUT_W:0] : rem_sh[OUT_W:0];
         root_in = {root_ff[OUT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(OUT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/core/pdm_datapath.sv
`timescale 1ns / 1ps
// Point store, distance arithmetic and result registers.
module pdm_datapath #(
   parameter int MAX_POINTS  = 64,
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdm_pkg::cmd_type              cmd,
   output pdm_pkg::stat_type             stat,
   input  logic [$clog2(MAX_POINTS)-1:0] row_idx,
   input  logic [$clog2(MAX_POINTS)-1:0] col_idx,
   input  logic signed [COORD_WIDTH-1:0] pos_x,
   input  logic signed [COORD_WIDTH-1:0] pos_y,
   input  logic signed [COORD_WIDTH-1:0] pos_z,
   input  logic                          present,
   output logic                          rsp_valid,
   output logic [pdm_pkg::IDX_WIDTH-1:0] rsp_row_index,
   output logic [pdm_pkg::IDX_WIDTH-1:0] rsp_col_index,
   output logic [pdm_pkg::DIST_WIDTH-1:0] rsp_distance,
   output logic                          rsp_distance_defined,
   output logic                          rsp_last_of_run
);
   import pdm_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int PW   = 3 * W + 1;
   localparam int SW   = 2 * W + 2;
   localparam int RW   = W + 1;
   localparam int CW   = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;

   logic [PW-1:0] mem [MAX_POINTS];
   logic [PW-1:0] rd_ff;
   logic [PW-1:0] cur_ff;

   logic [W-1:0]   dx_ff, dy_ff, dz_ff;
   logic [2*W-1:0] sx_ff, sy_ff, sz_ff;
   logic [SW-1:0]  sum_ff;
   logic [RW-1:0]  root;
   logic           root_done;
   logic [CW-1:0]  root_ext;
   logic [DIST_WIDTH-1:0] dist_clamped;

   logic                  valid_ff;
   logic [IDX_WIDTH-1:0]  row_ff, col_ff;
   logic [DIST_WIDTH-1:0] dist_ff;
   logic                  def_ff, last_ff;

   function automatic logic [W-1:0] abs_diff(input logic [W-1:0] a, input logic [W-1:0] b);
      logic signed [W:0] d;
      d = $signed({a[W-1], a}) - $signed({b[W-1], b});
      return d[W] ? W'(-d) : d[W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[col_idx] <= {present, pos_z, pos_y, pos_x};
         cur_ff       <= {present, pos_z, pos_y, pos_x};
      end
      if (cmd.rd) begin
         rd_ff <= mem[row_idx];
      end
   end

   assign stat.both      = rd_ff[PW-1] & cur_ff[PW-1];
   assign stat.root_done = root_done;

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         dx_ff <= abs_diff(rd_ff[W-1:0], cur_ff[W-1:0]);
         dy_ff <= abs_diff(rd_ff[2*W-1:W], cur_ff[2*W-1:W]);
         dz_ff <= abs_diff(rd_ff[3*W-1:2*W], cur_ff[3*W-1:2*W]);
      end
      if (cmd.load_sq) begin
         sx_ff <= dx_ff * dx_ff;
         sy_ff <= dy_ff * dy_ff;
         sz_ff <= dz_ff * dz_ff;
      end
      if (cmd.load_sum) begin
         sum_ff <= SW'(sx_ff) + SW'(sy_ff) + SW'(sz_ff);
      end
   end

   pdm_isqrt #(.IN_W(SW)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root)
   );

   assign root_ext     = CW'(root);
   assign dist_clamped = (root_ext > CW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.emit_pair) begin
         row_ff  <= IDX_WIDTH'(row_idx);
         col_ff  <= IDX_WIDTH'(col_idx);
         dist_ff <= stat.both ? dist_clamped : '0;
         def_ff  <= stat.both;
         last_ff <= 1'b0;
      end else if (cmd.emit_diag) begin
         row_ff  <= IDX_WIDTH'(col_idx);
         col_ff  <= IDX_WIDTH'(col_idx);
         dist_ff <= '0;
         def_ff  <= 1'b1;
         last_ff <= 1'b1;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit_pair | cmd.emit_diag;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_row_index        = row_ff;
   assign rsp_col_index        = col_ff;
   assign rsp_distance         = dist_ff;
   assign rsp_distance_defined = def_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

### rtl/core/pdm_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine: point indexing and pair walk.
module pdm_ctrl #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          first_of_set,
   output logic                          busy,
   output pdm_pkg::cmd_type              cmd,
   input  pdm_pkg::stat_type             stat,
   output logic [$clog2(MAX_POINTS)-1:0] row_idx,
   output logic [$clog2(MAX_POINTS)-1:0] col_idx
);
   import pdm_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NEXT  = 3'd1;
   localparam logic [2:0] S_DIFF  = 3'd2;
   localparam logic [2:0] S_SQ    = 3'd3;
   localparam logic [2:0] S_SUM   = 3'd4;
   localparam logic [2:0] S_START = 3'd5;
   localparam logic [2:0] S_WAIT  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] j_ff, j_in;
   logic [NW-1:0] eff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      j_in     = j_ff;
      eff      = first_of_set ? '0 : count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && eff < NW'(MAX_POINTS)) begin
               cmd.store = 1'b1;
               count_in  = eff;
               idx_in    = eff[IW-1:0];
               j_in      = '0;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (j_ff == idx_ff) begin
               cmd.emit_diag = 1'b1;
               count_in      = NW'(idx_ff) + 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            if (stat.both) begin
               cmd.load_diff = 1'b1;
               state_in      = S_SQ;
            end else begin
               cmd.emit_pair = 1'b1;
               j_in          = j_ff + 1'b1;
               state_in      = S_NEXT;
            end
         end
         S_SQ: begin
            cmd.load_sq = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.load_sum = 1'b1;
            state_in     = S_START;
         end
         S_START: begin
            cmd.root_start = 1'b1;
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (stat.root_done) begin
               cmd.emit_pair = 1'b1;
               j_in          = j_ff + 1'b1;
               state_in      = S_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         j_ff     <= j_in;
      end
   end

   assign busy    = state_ff != S_IDLE;
   assign row_idx = j_ff;
   // The store write happens at acceptance, before the new index is registered.
   assign col_idx = cmd.store ? idx_in : idx_ff;

   a_row_not_past_col: assert property (@(posedge clock) disable iff (reset)
      busy |-> j_ff <= idx_ff)
      else $error("row index ran past the current point");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_POINTS))
      else $error("point count exceeds store depth");

   a_single_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_pair && cmd.emit_diag))
      else $error("pair and diagonal beat issued together");

   a_diag_ends_run: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_diag |=> !busy && count_ff == NW'($past(idx_ff)) + 1'b1)
      else $error("diagonal beat did not close the run");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pairwise distance matrix block.
module tb_top;

   import pdm_pkg::*;

   localparam int MAX_PTS = 64;
   localparam int CW      = 20;

   // One result beat as the block presents it.
   typedef struct {
      logic [IDX_WIDTH-1:0]  row;
      logic [IDX_WIDTH-1:0]  col;
      logic [DIST_WIDTH-1:0] span;
      logic                  defined;
      logic                  last;
   } beat_t;

   // One row of the directed stimulus table. Where typed is set, the expected
   // diagonal beat is written into the row and used in place of the predicted one.
   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 present;
      logic                 first;
      bit                   typed;
      beat_t                want;
   } step_t;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] req_pos_x = '0;
   logic signed [CW-1:0] req_pos_y = '0;
   logic signed [CW-1:0] req_pos_z = '0;
   logic req_present = 1'b0;
   logic req_first_of_set = 1'b0;
   logic rsp_valid;
   logic [IDX_WIDTH-1:0]  rsp_row_index;
   logic [IDX_WIDTH-1:0]  rsp_col_index;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic rsp_distance_defined;
   logic rsp_last_of_run;

   // Side band that travels with each beat offered to the block: whether its
   // expectation comes from the table rather than from the predictor.
   bit    offer_typed = 1'b0;
   beat_t offer_want  = '{default: '0};

   // Predictor state: its own copy of the point store and the set fill level.
   logic signed [CW-1:0] pts_x [MAX_PTS];
   logic signed [CW-1:0] pts_y [MAX_PTS];
   logic signed [CW-1:0] pts_z [MAX_PTS];
   logic                 pts_present [MAX_PTS];
   int                   set_fill = 0;

   beat_t pending_beats [$];
   int    mismatches  = 0;
   int    points_sent = 0;
   int    beats_seen  = 0;
   int    dropped     = 0;

   step_t plan [$];

   pairwise_distance_matrix #(.MAX_POINTS(MAX_PTS), .COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_present(req_present), .req_first_of_set(req_first_of_set),
      .rsp_valid(rsp_valid), .rsp_row_index(rsp_row_index),
      .rsp_col_index(rsp_col_index), .rsp_distance(rsp_distance),
      .rsp_distance_defined(rsp_distance_defined), .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Floor of the square root, one result bit at a time.
   function automatic longint unsigned floor_root(input longint unsigned num);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > num) b = b >> 2;
      while (b != 0) begin
         if (num >= res + b) begin
            num = num - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [DIST_WIDTH-1:0] point_gap(input int j, input logic signed [CW-1:0] x,
         input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
      longint dx;
      longint dy;
      longint dz;
      longint unsigned root;
      dx   = longint'(pts_x[j]) - longint'(x);
      dy   = longint'(pts_y[j]) - longint'(y);
      dz   = longint'(pts_z[j]) - longint'(z);
      root = floor_root(longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz));
      if (root > longint'(DIST_MAX)) root = longint'(DIST_MAX);
      return root[DIST_WIDTH-1:0];
   endfunction

   // Stores an accepted point and queues the beats of its run: one per earlier
   // point of the set, then the diagonal. A point that finds the store full, and
   // does not open a new set, is dropped and queues nothing.
   task automatic predict_run(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
         input logic signed [CW-1:0] z, input logic present, input logic first,
         input bit typed, input beat_t want);
      beat_t b;
      bit    both;
      if (first) set_fill = 0;
      if (set_fill >= MAX_PTS) begin
         dropped++;
         return;
      end
      pts_x[set_fill] = x;
      pts_y[set_fill] = y;
      pts_z[set_fill] = z;
      pts_present[set_fill] = present;
      for (int j = 0; j < set_fill; j++) begin
         both      = pts_present[j] && present;
         b.row     = j[IDX_WIDTH-1:0];
         b.col     = set_fill[IDX_WIDTH-1:0];
         b.span    = both ? point_gap(j, x, y, z) : '0;
         b.defined = both;
         b.last    = 1'b0;
         pending_beats = {pending_beats, b};
      end
      b.row     = set_fill[IDX_WIDTH-1:0];
      b.col     = set_fill[IDX_WIDTH-1:0];
      b.span    = '0;
      b.defined = 1'b1;
      b.last    = 1'b1;
      pending_beats = {pending_beats, (typed ? want : b)};
      set_fill++;
   endtask

   // Result checking and acceptance tracking, both on the pre-edge values.
   // Results are checked first; a beat can never appear at its own acceptance edge.
   always @(posedge clock) begin
      beat_t w;
      if (!reset && rsp_valid) begin
         beats_seen++;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat row %0d col %0d dist %0d def %0b last %0b",
                     $time, rsp_row_index, rsp_col_index, rsp_distance,
                     rsp_distance_defined, rsp_last_of_run);
            mismatches++;
         end else begin
            w = pending_beats.pop_front();
            if (rsp_row_index !== w.row || rsp_col_index !== w.col ||
                rsp_distance !== w.span || rsp_distance_defined !== w.defined ||
                rsp_last_of_run !== w.last) begin
               $display("%0t: beat mismatch, expected row %0d col %0d dist %0d def %0b last %0b",
                        $time, w.row, w.col, w.span, w.defined, w.last);
               $display("%0t:                actual   row %0d col %0d dist %0d def %0b last %0b",
                        $time, rsp_row_index, rsp_col_index, rsp_distance,
                        rsp_distance_defined, rsp_last_of_run);
               mismatches++;
            end
         end
      end
      if (!reset && start && !busy) begin
         points_sent++;
         predict_run(req_pos_x, req_pos_y, req_pos_z, req_present, req_first_of_set,
                     offer_typed, offer_want);
      end
   end

   // Mostly back to back or short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // Offers one point and returns at the edge that accepts it. Start is only
   // lowered when a pause follows, so a back-to-back beat keeps it high.
   task automatic offer_point(input step_t s, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_pos_x        <= s.x;
      req_pos_y        <= s.y;
      req_pos_z        <= s.z;
      req_present      <= s.present;
      req_first_of_set <= s.first;
      offer_typed      <= s.typed;
      offer_want       <= s.want;
      do @(posedge clock); while (busy);
   endtask

   // Appends one row to the directed table.
   task automatic add_step(input step_t s);
      plan = {plan, s};
   endtask

   function automatic step_t plain(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
         input logic signed [CW-1:0] z, input logic present, input logic first);
      step_t s;
      s.x = x; s.y = y; s.z = z; s.present = present; s.first = first;
      s.typed = 1'b0;
      s.want  = '{default: '0};
      return s;
   endfunction

   // A set opener always lands at index zero with a lone diagonal beat.
   function automatic step_t opener(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
         input logic signed [CW-1:0] z, input logic present, input logic first);
      step_t s;
      s = plain(x, y, z, present, first);
      s.typed = 1'b1;
      s.want  = '{row: '0, col: '0, span: '0, defined: 1'b1, last: 1'b1};
      return s;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(input bit near);
      logic [CW-1:0] v;
      v = CW'($urandom());
      if (near) v = {{(CW-12){v[11]}}, v[11:0]};
      return v;
   endfunction

   initial begin
      int    cnt;
      int    gap;
      bit    near;
      bit    overfilled;
      step_t s;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The first point after reset has no start flag yet still
      // takes index zero; then extremes, a missing point, an exact 3-4-5 case,
      // a missing opener and opposite corners.
      add_step(opener(0, 0, 0, 1'b1, 1'b0));
      add_step(plain(CMAX, CMAX, CMAX, 1'b1, 1'b0));
      add_step(plain(CMIN, CMIN, CMIN, 1'b1, 1'b0));
      add_step(plain(256, 0, 0, 1'b0, 1'b0));
      add_step(plain(-1, -1, -1, 1'b1, 1'b0));
      add_step(opener(0, 0, 0, 1'b1, 1'b1));
      add_step(plain(768, 1024, 0, 1'b1, 1'b0));
      add_step(plain(0, 0, 1, 1'b1, 1'b0));
      add_step(opener(5, 5, 5, 1'b0, 1'b1));
      add_step(plain(1, 2, 3, 1'b1, 1'b0));
      add_step(plain(CMAX, CMIN, 0, 1'b0, 1'b0));
      add_step(opener(CMIN, CMAX, CMIN, 1'b1, 1'b1));
      add_step(plain(CMAX, CMIN, CMAX, 1'b1, 1'b0));
      add_step(plain(CMIN, CMAX, CMIN, 1'b1, 1'b0));
      foreach (plan[i]) offer_point(plan[i], pick_gap());

      // Random part: mostly small sets with random content, one set that
      // overfills the store so the extra points are dropped, and now and then
      // a point with no start flag that simply extends the current set.
      cnt        = 0;
      overfilled = 1'b0;
      while (cnt < 100) begin
         int size;
         if (!overfilled && cnt >= 40) begin
            size       = MAX_PTS + 3;
            overfilled = 1'b1;
         end else begin
            size = $urandom_range(7, 1);
         end
         near = 1'($urandom_range(1));
         for (int k = 0; k < size; k++) begin
            s = plain(rand_coord(near), rand_coord(near), rand_coord(near),
                      $urandom_range(9) != 0, k == 0 && $urandom_range(7) != 0);
            gap = (size > MAX_PTS) ? 0 : pick_gap();
            offer_point(s, gap);
            cnt++;
         end
      end
      start <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d points (%0d dropped on a full store), %0d result beats checked.",
               points_sent, dropped, beats_seen);
      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d beats outstanding.", pending_beats.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
